// File: sv/rrst_pkg.sv
package rrst_pkg;

    // Store sizing
    localparam int MAX_PROCESSES = 64;
    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    // Field widths
    localparam int BURST_W = 16;
    localparam int TIME_W  = 22;
    localparam int NUM_W   = 7;
    localparam int QUANT_W = 16;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd4;

    // Sequencer steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_PASS     = 4'd1;
    localparam logic [STEP_W-1:0] ST_RD_REM   = 4'd2;
    localparam logic [STEP_W-1:0] ST_EXEC     = 4'd3;
    localparam logic [STEP_W-1:0] ST_CHECK    = 4'd4;
    localparam logic [STEP_W-1:0] ST_OUT_INIT = 4'd5;
    localparam logic [STEP_W-1:0] ST_RD_OUT   = 4'd6;
    localparam logic [STEP_W-1:0] ST_EMIT     = 4'd7;
    localparam logic [STEP_W-1:0] ST_CLEAR    = 4'd8;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEXT       = 3'd0;
    localparam logic [COND_W-1:0] C_GOTO       = 3'd1;
    localparam logic [COND_W-1:0] C_START_LAST = 3'd2;
    localparam logic [COND_W-1:0] C_MORE       = 3'd3;
    localparam logic [COND_W-1:0] C_PROGRESS   = 3'd4;

    typedef struct packed {
        logic              busy;
        logic              load;
        logic              pass_init;
        logic              rd_rem;
        logic              exec;
        logic              out_init;
        logic              rd_out;
        logic              emit;
        logic              clear;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic idx_last;
        logic progress;
    } status_t;

    // Control store: one word per step
    function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        w.busy = 1'b1;
        unique case (step)
            ST_IDLE:
            begin
                w.busy = 1'b0;
                w.load = 1'b1;
                w.cond = C_START_LAST;
                w.target = ST_PASS;
            end
            ST_PASS:
            begin
                w.pass_init = 1'b1;
                w.cond = C_NEXT;
            end
            ST_RD_REM:
            begin
                w.rd_rem = 1'b1;
                w.cond = C_NEXT;
            end
            ST_EXEC:
            begin
                w.exec = 1'b1;
                w.cond = C_MORE;
                w.target = ST_RD_REM;
            end
            ST_CHECK:
            begin
                w.cond = C_PROGRESS;
                w.target = ST_PASS;
            end
            ST_OUT_INIT:
            begin
                w.out_init = 1'b1;
                w.cond = C_NEXT;
            end
            ST_RD_OUT:
            begin
                w.rd_out = 1'b1;
                w.cond = C_NEXT;
            end
            ST_EMIT:
            begin
                w.emit = 1'b1;
                w.cond = C_MORE;
                w.target = ST_RD_OUT;
            end
            ST_CLEAR:
            begin
                w.clear = 1'b1;
                w.cond = C_GOTO;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond = C_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: sv/rrst_sequencer.sv
module rrst_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last_process,
    input  rrst_pkg::status_t status,
    output rrst_pkg::ctrl_t   ctrl
);
    import rrst_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] step_inc;

    // Fetch the control word for the current step
    assign ctrl     = rom_word(step_reg);
    assign step_inc = step_reg + 1'b1;

    // Pick the next step from the word's condition
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:       step_next = step_inc;
            C_GOTO:       step_next = ctrl.target;
            C_START_LAST: step_next = (start && last_process) ? ctrl.target : step_reg;
            C_MORE:       step_next = status.idx_last ? step_inc : ctrl.target;
            C_PROGRESS:   step_next = status.progress ? ctrl.target : step_inc;
            default:      step_next = ST_IDLE;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: sv/rrst_datapath.sv
module rrst_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rrst_pkg::ctrl_t              ctrl,
    input  logic                         start,
    input  logic [15:0]                  burst_time,
    input  logic [15:0]                  quantum,
    output rrst_pkg::status_t            status,
    output logic                         result_valid,
    output logic [6:0]                   process_number,
    output logic [21:0]                  waiting_time,
    output logic [21:0]                  turnaround_time,
    output logic                         last_result
);
    import rrst_pkg::*;

    // Process stores
    logic [BURST_W-1:0] burst_mem  [MAX_PROCESSES];
    logic [BURST_W-1:0] rem_mem    [MAX_PROCESSES];
    logic [TIME_W-1:0]  finish_mem [MAX_PROCESSES];

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [TIME_W-1:0]  clock_reg, clock_next;
    logic               progress_reg, progress_next;
    logic [BURST_W-1:0] rem_q_reg;
    logic [BURST_W-1:0] burst_q_reg;
    logic [TIME_W-1:0]  fin_q_reg;

    logic               result_valid_reg;
    logic [NUM_W-1:0]   number_reg;
    logic [TIME_W-1:0]  wait_reg;
    logic [TIME_W-1:0]  tat_reg;
    logic               last_reg;

    logic [BURST_W-1:0] slice;
    logic               load_en;
    logic               rem_we;
    logic [BURST_W-1:0] rem_wdata;
    logic               fin_we;
    logic [CNT_W-1:0]   idx_plus;
    logic [31:0]        num_wide;
    logic [TIME_W-1:0]  wait_calc;

    assign slice    = (quantum == '0) ? {{(BURST_W-1){1'b0}}, 1'b1} : quantum;
    assign load_en  = ctrl.load && start && (count_reg < CNT_W'(MAX_PROCESSES));
    assign idx_plus = CNT_W'(idx_reg) + 1'b1;
    assign num_wide = 32'(idx_reg) + 32'd1;

    assign status.idx_last = (idx_plus == count_reg);
    assign status.progress = progress_reg;

    // Next-state logic: count loads, pass and output starts, one turn of the visited process, emit steps and clear
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        clock_next    = clock_reg;
        progress_next = progress_reg;
        rem_we        = 1'b0;
        rem_wdata     = rem_q_reg;
        fin_we        = 1'b0;
        if (load_en)
        begin
            count_next = count_reg + 1'b1;
        end
        if (ctrl.pass_init)
        begin
            idx_next      = '0;
            progress_next = 1'b0;
        end
        if (ctrl.out_init)
        begin
            idx_next = '0;
        end
        if (ctrl.exec)
        begin
            idx_next = idx_reg + 1'b1;
            if (rem_q_reg != '0)
            begin
                progress_next = 1'b1;
                rem_we        = 1'b1;
                if (rem_q_reg > slice)
                begin
                    clock_next = clock_reg + TIME_W'(slice);
                    rem_wdata  = rem_q_reg - slice;
                end
                else
                begin
                    clock_next = clock_reg + TIME_W'(rem_q_reg);
                    rem_wdata  = '0;
                    fin_we     = 1'b1;
                end
            end
        end
        if (ctrl.emit)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (ctrl.clear)
        begin
            count_next = '0;
            clock_next = '0;
        end
    end

    // Hold control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            idx_reg          <= '0;
            clock_reg        <= '0;
            progress_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            clock_reg        <= clock_next;
            progress_reg     <= progress_next;
            result_valid_reg <= ctrl.emit;
        end
    end

    // Write and read the process stores
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            burst_mem[count_reg[IDX_W-1:0]] <= burst_time;
            rem_mem[count_reg[IDX_W-1:0]]   <= burst_time;
        end
        else if (rem_we)
        begin
            rem_mem[idx_reg] <= rem_wdata;
        end
        if (fin_we)
        begin
            finish_mem[idx_reg] <= clock_next;
        end
        if (ctrl.rd_rem)
        begin
            rem_q_reg <= rem_mem[idx_reg];
        end
        if (ctrl.rd_out)
        begin
            burst_q_reg <= burst_mem[idx_reg];
            fin_q_reg   <= finish_mem[idx_reg];
        end
    end

    assign wait_calc = fin_q_reg - TIME_W'(burst_q_reg);

    // Register the outgoing word
    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            number_reg <= num_wide[NUM_W-1:0];
            last_reg   <= status.idx_last;
            if (burst_q_reg == '0)
            begin
                wait_reg <= '0;
                tat_reg  <= '0;
            end
            else
            begin
                wait_reg <= wait_calc;
                tat_reg  <= fin_q_reg;
            end
        end
    end

    assign result_valid    = result_valid_reg;
    assign process_number  = number_reg;
    assign waiting_time    = wait_reg;
    assign turnaround_time = tat_reg;
    assign last_result     = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PROCESSES))
        else $error("process count beyond store depth");

    a_clock_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.busy |-> (clock_reg == '0))
        else $error("schedule clock not cleared at idle");

    a_progress_set: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.exec && (rem_q_reg != '0)) |=> progress_reg)
        else $error("turn ran without marking progress");

    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.busy && !ctrl.clear) |-> (count_reg != '0))
        else $error("schedule running on an empty set");
`endif

endmodule

// File: sv/round_robin_schedule_timing_unit.sv
// Round-robin schedule timing unit.
// Input: pulse start with burst_time and last_process while busy is low;
// each such cycle stores one process burst (one word per cycle) until 64
// are held. A word with last_process high closes the set and raises busy.
// The control sequencer then walks round-robin passes over the stored
// set: a read and an execute step per visited process, a start and a check
// step per pass, repeated until a pass finds no remaining time, the rem
// store read port setting the pace. An out-init step opens the results,
// which follow in index order, a read and an emit step each, each shown
// for exactly one cycle with result_valid high; last_result marks the
// final process. Busy falls in the cycle after the last word and the next
// set may load. The receiver cannot stall, so results are never held.
// Quantum is written over the APB port at byte addresses 0 to 3; the user
// must write it only while idle, which the block does not enforce. A
// quantum of zero runs as one. Reset sets quantum to 4, empties the set
// and returns the sequencer to idle; no clearing pass is needed.
module round_robin_schedule_timing_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] burst_time,
    input  logic        last_process,
    output logic        result_valid,
    output logic [6:0]  process_number,
    output logic [21:0] waiting_time,
    output logic [21:0] turnaround_time,
    output logic        last_result
);
    import rrst_pkg::*;

    ctrl_t              ctrl;
    status_t            status;
    logic [QUANT_W-1:0] quantum_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign prdata    = paddr[2] ? '0 : APB_DATA_W'(quantum_reg);
    assign busy      = ctrl.busy;

    // Hold the quantum register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_write)
        begin
            quantum_reg <= pwdata[QUANT_W-1:0];
        end
    end

    rrst_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_process (last_process),
        .status       (status),
        .ctrl         (ctrl)
    );

    rrst_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .start           (start),
        .burst_time      (burst_time),
        .quantum         (quantum_reg),
        .status          (status),
        .result_valid    (result_valid),
        .process_number  (process_number),
        .waiting_time    (waiting_time),
        .turnaround_time (turnaround_time),
        .last_result     (last_result)
    );

endmodule

// File: verif/rr_timing_checker.sv
`timescale 1ns / 100ps

// Watches the burst, result and APB channels of the schedule timing unit,
// predicts each process report and compares it with what the unit emits.
module rr_timing_checker
    import rrst_pkg::*;
#(
    parameter logic [APB_ADDR_W-1:0] QUANTUM_ADDR = '0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    input  logic                  start,
    input  logic                  busy,
    input  logic [BURST_W-1:0]    burst_time,
    input  logic                  last_process,
    input  logic                  result_valid,
    input  logic [NUM_W-1:0]      process_number,
    input  logic [TIME_W-1:0]     waiting_time,
    input  logic [TIME_W-1:0]     turnaround_time,
    input  logic                  last_result,
    output int                    fail_count,
    output int                    pending,
    output int                    report_count,
    output int                    set_count
);

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [TIME_W-1:0] wait_t;
        logic [TIME_W-1:0] tat;
        logic              last;
    } report_t;

    logic [BURST_W-1:0] burst_mem [MAX_PROCESSES];
    int                 stored;
    logic [QUANT_W-1:0] quantum_copy;
    report_t            expected_reports [$];
    int                 mismatch_seen;

    // Walk the round-robin passes over the stored set and queue one report per process
    function automatic void predict_reports();
        logic [BURST_W-1:0] left   [MAX_PROCESSES];
        logic [TIME_W-1:0]  finish [MAX_PROCESSES];
        logic [TIME_W-1:0]  now;
        logic [QUANT_W-1:0] slice;
        int                 finished;
        bit                 moved;
        report_t            r;
        slice = (quantum_copy == '0) ? QUANT_W'(1) : quantum_copy;
        now = '0;
        finished = 0;
        for (int i = 0; i < stored; i++)
        begin
            left[i] = burst_mem[i];
            finish[i] = '0;
        end
        while (finished < stored)
        begin
            moved = 1'b0;
            for (int i = 0; i < stored; i++)
            begin
                if (left[i] != '0)
                begin
                    moved = 1'b1;
                    if (left[i] > slice)
                    begin
                        now = now + TIME_W'(slice);
                        left[i] = left[i] - slice;
                    end
                    else
                    begin
                        now = now + TIME_W'(left[i]);
                        finish[i] = now;
                        left[i] = '0;
                        finished++;
                    end
                end
            end
            if (!moved)
                break;
        end
        for (int i = 0; i < stored; i++)
        begin
            r.num = NUM_W'(i + 1);
            r.tat = (burst_mem[i] == '0) ? '0 : finish[i];
            r.wait_t = (burst_mem[i] == '0) ? '0 : finish[i] - TIME_W'(burst_mem[i]);
            r.last = (i == stored - 1);
            expected_reports.push_back(r);
        end
        stored = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        report_t got;
        report_t exp_r;
        if (!rst_n)
        begin
            stored = 0;
            quantum_copy = QUANTUM_RESET;
            expected_reports.delete();
            fail_count = 0;
            mismatch_seen = 0;
            report_count = 0;
            set_count = 0;
            pending = 0;
        end
        else
        begin
            // Track quantum writes and check readback
            if (psel && penable && pready && paddr == QUANTUM_ADDR)
            begin
                if (pwrite)
                    quantum_copy = pwdata[QUANT_W-1:0];
                else if (prdata[QUANT_W-1:0] !== quantum_copy)
                begin
                    fail_count++;
                    mismatch_seen++;
                    if (mismatch_seen <= 10)
                        $display("quantum readback: expected %0d, got %0d",
                                 quantum_copy, prdata[QUANT_W-1:0]);
                end
            end

            // Compare each emitted word with the oldest expected report
            if (result_valid)
            begin
                got = '{process_number, waiting_time, turnaround_time, last_result};
                report_count++;
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    mismatch_seen++;
                    if (mismatch_seen <= 10)
                        $display("unexpected report: num %0d wait %0d tat %0d last %0d",
                                 got.num, got.wait_t, got.tat, got.last);
                end
                else
                begin
                    exp_r = expected_reports.pop_front();
                    if (got !== exp_r)
                    begin
                        fail_count++;
                        mismatch_seen++;
                        if (mismatch_seen <= 10)
                            $display("report mismatch: expected num %0d wait %0d tat %0d last %0d, got num %0d wait %0d tat %0d last %0d",
                                     exp_r.num, exp_r.wait_t, exp_r.tat, exp_r.last,
                                     got.num, got.wait_t, got.tat, got.last);
                    end
                end
            end

            // Store accepted bursts; drop them once the store is full
            if (start && !busy)
            begin
                if (stored < MAX_PROCESSES)
                begin
                    burst_mem[stored] = burst_time;
                    stored++;
                end
                if (last_process)
                begin
                    predict_reports();
                    set_count++;
                end
            end
            pending = expected_reports.size();
        end
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rrst_pkg::*;

    localparam logic [APB_ADDR_W-1:0] QUANTUM_ADDR = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    logic [BURST_W-1:0]    burst_time;
    logic                  last_process;
    logic                  result_valid;
    logic [NUM_W-1:0]      process_number;
    logic [TIME_W-1:0]     waiting_time;
    logic [TIME_W-1:0]     turnaround_time;
    logic                  last_result;

    int fail_count;
    int pending;
    int report_count;
    int set_count;

    int                 idle_pct;
    int                 words_sent;
    logic [BURST_W-1:0] set_bursts [$];

    round_robin_schedule_timing_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .burst_time      (burst_time),
        .last_process    (last_process),
        .result_valid    (result_valid),
        .process_number  (process_number),
        .waiting_time    (waiting_time),
        .turnaround_time (turnaround_time),
        .last_result     (last_result)
    );

    rr_timing_checker #(.QUANTUM_ADDR(QUANTUM_ADDR)) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .burst_time      (burst_time),
        .last_process    (last_process),
        .result_valid    (result_valid),
        .process_number  (process_number),
        .waiting_time    (waiting_time),
        .turnaround_time (turnaround_time),
        .last_result     (last_result),
        .fail_count      (fail_count),
        .pending         (pending),
        .report_count    (report_count),
        .set_count       (set_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Offer one burst word, idling beforehand at the current rate
    task automatic send_word(input logic [BURST_W-1:0] b, input logic l);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            burst_time <= BURST_W'($urandom);
            last_process <= 1'($urandom);
        end
        @(negedge clk);
        start <= 1'b1;
        burst_time <= b;
        last_process <= l;
        do @(posedge clk); while (busy);
        words_sent++;
    endtask

    // Drop start and hold until every report is out and the unit is idle
    task automatic wait_drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [QUANT_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= QUANTUM_ADDR;
        pwdata <= {16'($urandom), data};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'($urandom);
        paddr <= APB_ADDR_W'($urandom);
        pwdata <= $urandom;
    endtask

    task automatic set_quantum(input logic [QUANT_W-1:0] q);
        apb_access(1'b1, q);
        apb_access(1'b0, q);
    endtask

    task automatic run_set();
        for (int i = 0; i < set_bursts.size(); i++)
            send_word(set_bursts[i], i == set_bursts.size() - 1);
        wait_drain();
    endtask

    initial
    begin
        int                 target;
        int                 n;
        int                 passes;
        int                 cap;
        int                 slice;
        logic [QUANT_W-1:0] q;
        int                 full_done;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        burst_time = '0;
        last_process = 1'b0;
        words_sent = 0;
        full_done = 0;
        idle_pct = 35;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset quantum, zero bursts, exact and partial slices
        apb_access(1'b0, QUANTUM_RESET);
        set_bursts = '{16'd0, 16'd1, 16'd4, 16'd5, 16'd9};
        run_set();
        set_bursts = '{16'd0, 16'd0};
        run_set();
        set_quantum(16'd1);
        set_bursts = '{16'd3, 16'd1, 16'd2};
        run_set();
        // A zero quantum runs as one
        set_quantum(16'd0);
        set_bursts = '{16'd2, 16'd0, 16'd3};
        run_set();
        set_quantum(16'hFFFF);
        set_bursts = '{16'hFFFF, 16'd0, 16'h8000, 16'hFFFF};
        run_set();
        set_quantum(16'h8000);
        set_bursts = '{16'hFFFF, 16'd1};
        run_set();

        // Random sets in three idling phases
        target = words_sent;
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 35 : (phase == 1) ? 80 : 0;
            target = target + 80;
            while (words_sent < target)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    case ($urandom_range(0, 6))
                        0:       q = 16'd1;
                        1:       q = 16'd4;
                        2:       q = 16'hFFFF;
                        3:       q = QUANT_W'(1 << $urandom_range(0, 15));
                        4:       q = 16'd0;
                        default: q = QUANT_W'($urandom_range(1, 65535));
                    endcase
                    set_quantum(q);
                end
                else
                begin
                    q = u_check.quantum_copy;
                end
                slice = (q == 0) ? 1 : int'(q);
                // Overfill the store once, and now and then send 60 to 70 bursts at random
                if ((phase == 2 && full_done == 0) || $urandom_range(0, 19) == 0)
                begin
                    n = $urandom_range(60, 70);
                    if (phase == 2 && full_done == 0)
                        n = MAX_PROCESSES + 2;
                    full_done = 1;
                end
                else
                begin
                    n = $urandom_range(1, 8);
                end
                passes = (n > 16) ? $urandom_range(1, 3) : $urandom_range(1, 12);
                cap = slice * passes;
                if (cap > 65535)
                    cap = 65535;
                set_bursts.delete();
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 7))
                        0:       set_bursts.push_back(16'd0);
                        1:       set_bursts.push_back(BURST_W'(cap));
                        default: set_bursts.push_back(BURST_W'($urandom_range(0, cap)));
                    endcase
                end
                run_set();
            end
        end

        wait_drain();
        repeat (20) @(posedge clk);
        @(negedge clk);
        $display("Covered %0d sets from %0d burst words, %0d process reports checked,",
                 set_count, words_sent, report_count);
        $display("quantum from zero to full scale, zero bursts and store overflow.");
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
sv/rrst_pkg.sv
sv/rrst_sequencer.sv
sv/rrst_datapath.sv
sv/round_robin_schedule_timing_unit.sv
verif/rr_timing_checker.sv
verif/testbench.sv
